// ----- design/pbt_pkg.sv -----
`timescale 1ns / 1ps

package pbt_pkg;

    localparam int BLOCK_LEN     = 100;
    localparam int WINDOW_BLOCKS = 4;
    localparam int SAMPLE_BITS   = 18;

    localparam int LEVEL_W   = 8;
    localparam int IN_W      = 18;
    localparam int PROD_W    = SAMPLE_BITS + LEVEL_W;
    localparam int POS_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int SLOT_W    = (WINDOW_BLOCKS > 1) ? $clog2(WINDOW_BLOCKS) : 1;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK = {SAMPLE_BITS{1'b1}};
    localparam logic [LEVEL_W-1:0]     FULL_SCALE_RST = {LEVEL_W{1'b1}};

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic freeze;
        logic update;
    } win_ctrl_t;

    typedef struct packed {
        logic block_start;
        logic freeze_last;
    } win_stat_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FREEZE = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_UPDATE = 5'b10000
    } seq_state_t;

endpackage

// ----- design/pbt_divider.sv -----
`timescale 1ns / 1ps

module pbt_divider
    import pbt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  sample_t           divisor,
    output logic              done,
    output logic [PROD_W-1:0] quotient
);

    logic [PROD_W-1:0]    dvd_reg, dvd_next;
    sample_t              rem_reg, rem_next;
    sample_t              dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SAMPLE_BITS:0] rem_sh;
    logic [SAMPLE_BITS:0] rem_sub;
    logic                 q_bit;

    // Restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[PROD_W-1]};
        rem_sub = rem_sh - {1'b0, dsr_reg};
        q_bit   = (rem_sh >= {1'b0, dsr_reg});
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[PROD_W-2:0], q_bit};
            rem_next = q_bit ? rem_sub[SAMPLE_BITS-1:0] : rem_sh[SAMPLE_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- design/pbt_window.sv -----
`timescale 1ns / 1ps

module pbt_window
    import pbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  win_ctrl_t ctrl,
    input  sample_t   sample,
    output win_stat_t stat,
    output sample_t   frozen_min,
    output sample_t   frozen_max
);

    sample_t           minima_reg [WINDOW_BLOCKS];
    sample_t           maxima_reg [WINDOW_BLOCKS];
    sample_t           run_min_reg, run_min_next;
    sample_t           run_max_reg, run_max_next;
    sample_t           fmin_reg, fmin_next;
    sample_t           fmax_reg, fmax_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              block_end;
    logic              idx_last;
    sample_t           base_min, base_max;
    sample_t           upd_min, upd_max;

    assign idx_last  = (idx_reg == SLOT_W'(WINDOW_BLOCKS - 1));
    assign block_end = (pos_reg == POS_W'(BLOCK_LEN - 1));

    always_comb
    begin
        // The first slot of a sweep compares against the empty-window bounds
        base_min  = (idx_reg == '0) ? SAMPLE_MASK : fmin_reg;
        base_max  = (idx_reg == '0) ? '0 : fmax_reg;
        fmin_next = fmin_reg;
        fmax_next = fmax_reg;
        idx_next  = idx_reg;
        if (ctrl.freeze)
        begin
            fmin_next = (minima_reg[idx_reg] < base_min) ? minima_reg[idx_reg] : base_min;
            fmax_next = (maxima_reg[idx_reg] > base_max) ? maxima_reg[idx_reg] : base_max;
            idx_next  = idx_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        upd_min      = (sample < run_min_reg) ? sample : run_min_reg;
        upd_max      = (sample > run_max_reg) ? sample : run_max_reg;
        run_min_next = run_min_reg;
        run_max_next = run_max_reg;
        pos_next     = pos_reg;
        slot_next    = slot_reg;
        if (ctrl.update)
        begin
            if (block_end)
            begin
                run_min_next = SAMPLE_MASK;
                run_max_next = '0;
                pos_next     = '0;
                slot_next    = (slot_reg == SLOT_W'(WINDOW_BLOCKS - 1)) ? '0
                                                                       : slot_reg + 1'b1;
            end
            else
            begin
                run_min_next = upd_min;
                run_max_next = upd_max;
                pos_next     = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_BLOCKS; k++)
            begin
                minima_reg[k] <= '0;
                maxima_reg[k] <= '0;
            end
            run_min_reg <= SAMPLE_MASK;
            run_max_reg <= '0;
            fmin_reg    <= '0;
            fmax_reg    <= '0;
            pos_reg     <= '0;
            slot_reg    <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (ctrl.update && block_end)
            begin
                minima_reg[slot_reg] <= upd_min;
                maxima_reg[slot_reg] <= upd_max;
            end
            run_min_reg <= run_min_next;
            run_max_reg <= run_max_next;
            fmin_reg    <= fmin_next;
            fmax_reg    <= fmax_next;
            pos_reg     <= pos_next;
            slot_reg    <= slot_next;
            idx_reg     <= idx_next;
        end
    end

    assign stat.block_start = (pos_reg == '0);
    assign stat.freeze_last = idx_last;
    assign frozen_min       = fmin_reg;
    assign frozen_max       = fmax_reg;

endmodule

// ----- design/pulse_brightness_tracker_core.sv -----
`timescale 1ns / 1ps

// Indicator brightness from a red PPG stream. Each accepted sample produces one
// result (brightness, range_zero). The result is registered after these steps:
// scale the change by full_scale and start the bit-serial divider, run the
// divider (26 quotient bits, then a done flag), and apply the saturating level
// update. On the first sample of each 100-sample block a sweep of the four
// stored block minima/maxima comes first. When the frozen range is zero the
// divider is skipped. A new sample is accepted only once the result of the
// last one is registered, and that can wait on out_stall.
// in_stall stays high while a sample is in progress; a finished result may wait
// in the output register while the next sample is accepted.
// full_scale_we writes full_scale; write it only while the block is idle.

module pulse_brightness_tracker_core
    import pbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               full_scale_we,
    input  logic [LEVEL_W-1:0] full_scale_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [IN_W-1:0]    red_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [LEVEL_W-1:0] brightness,
    output logic               range_zero
);

    seq_state_t         state_reg, state_next;
    logic [LEVEL_W-1:0] fs_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    sample_t            sample_reg;
    sample_t            prev_reg;
    logic               rise_reg;
    logic               zero_reg;
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] brightness_reg;
    logic               range_zero_reg;

    win_ctrl_t          win_ctrl;
    win_stat_t          win_stat;
    sample_t            frozen_min, frozen_max;
    sample_t            range;
    sample_t            diff;
    logic [PROD_W-1:0]  prod;
    logic               rise;
    logic               range_is_zero;
    logic               in_fire;
    logic               out_fire;
    logic               div_start;
    logic               div_done;
    logic [PROD_W-1:0]  delta;
    logic [PROD_W:0]    level_sum;

    assign in_fire       = in_valid && !in_stall;
    assign out_fire      = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);
    assign range_is_zero = (frozen_max <= frozen_min);
    assign range         = frozen_max - frozen_min;
    assign rise          = (sample_reg > prev_reg);
    assign diff          = rise ? (sample_reg - prev_reg) : (prev_reg - sample_reg);
    assign prod          = PROD_W'(diff) * PROD_W'(fs_reg);
    assign div_start     = (state_reg == ST_MUL) && !range_is_zero;

    assign win_ctrl.freeze = (state_reg == ST_FREEZE);
    assign win_ctrl.update = out_fire;

    pbt_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win_ctrl),
        .sample     (sample_reg),
        .stat       (win_stat),
        .frozen_min (frozen_min),
        .frozen_max (frozen_max)
    );

    pbt_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (range),
        .done     (div_done),
        .quotient (delta)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = win_stat.block_start ? ST_FREEZE : ST_MUL;
            end
            ST_FREEZE:
            begin
                if (win_stat.freeze_last)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = range_is_zero ? ST_UPDATE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Rise lowers the level toward 0, fall or flat raises it toward full_scale; a zero range holds it
    always_comb
    begin
        level_sum  = {1'b0, delta} + (PROD_W + 1)'(level_reg);
        level_next = level_reg;
        if (!zero_reg)
        begin
            if (rise_reg)
                level_next = (delta >= PROD_W'(level_reg)) ? '0
                                                           : level_reg - delta[LEVEL_W-1:0];
            else
                level_next = (level_sum > (PROD_W + 1)'(fs_reg)) ? fs_reg
                                                                 : level_sum[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fs_reg        <= FULL_SCALE_RST;
            level_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (full_scale_we)
                fs_reg <= full_scale_wdata;
            if (out_fire)
            begin
                level_reg     <= level_next;
                prev_reg      <= sample_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_reg <= red_sample[SAMPLE_BITS-1:0];
        if (state_reg == ST_MUL)
        begin
            rise_reg <= rise;
            zero_reg <= range_is_zero;
        end
        if (out_fire)
        begin
            brightness_reg <= level_next;
            range_zero_reg <= zero_reg;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign brightness = brightness_reg;
    assign range_zero = range_zero_reg;

endmodule
